// ===== hw/rtl/pdcm_pkg.sv =====
// Package for the PWM duty capture meter.
// Payload structs, command/status structs, opcodes and sizing constants.
// No dependencies.
package pdcm_pkg;

  localparam int unsigned CounterSpan = 65536;
  localparam int unsigned SpanShift   = $clog2(CounterSpan);

  localparam int unsigned CapW   = 16;
  localparam int unsigned OvfW   = 32;
  localparam int unsigned TicksW = 48;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned TotW   = TicksW + 1;  // ovf*span + cap stays below 2^49
  localparam int unsigned NumW   = TicksW + 8;  // high*100 and period<<7 both fit
  localparam int unsigned CntW   = $clog2(DutyW);

  localparam logic [DutyW-1:0] DutyMax   = DutyW'(100);
  localparam logic [NumW-1:0]  DutyScale = NumW'(100);

  // input beat opcodes
  localparam logic OpOverflow = 1'b0;
  localparam logic OpEdge     = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [CapW-1:0] capture_value;
  } in_t;

  typedef struct packed {
    logic [TicksW-1:0] high_ticks;
    logic [TicksW-1:0] period_ticks;
    logic [DutyW-1:0]  duty_percent;
    logic              zero_period;
  } out_t;

  typedef struct packed {
    logic ovf_inc;
    logic cap_load;
    logic total_calc;
    logic held_load;
    logic period_load;
    logic restart;
    logic mul;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_skip;
    logic div_last;
  } status_t;

endpackage

// ===== hw/rtl/pdcm_dpath.sv =====
// Datapath of the PWM duty capture meter: stamps, overflow count, span
// arithmetic, restoring divider and output register. Uses pdcm_pkg.
module pdcm_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdcm_pkg::in_t     in_data_i,
  input  pdcm_pkg::cmd_t    cmd_i,
  output pdcm_pkg::status_t status_o,
  output pdcm_pkg::out_t    out_data_o
);

  logic [pdcm_pkg::OvfW-1:0]   ovf_q;
  logic [pdcm_pkg::CapW-1:0]   start_q;
  logic [pdcm_pkg::TicksW-1:0] held_q;

  logic [pdcm_pkg::CapW-1:0]   cap_q;
  logic [pdcm_pkg::TotW-1:0]   total_q;
  logic [pdcm_pkg::TicksW-1:0] period_q;
  logic [pdcm_pkg::NumW-1:0]   num_q;
  logic [pdcm_pkg::NumW-1:0]   rem_q;
  logic [pdcm_pkg::DutyW-1:0]  quot_q;
  logic [pdcm_pkg::CntW-1:0]   cnt_q;
  logic                        zp_q;
  pdcm_pkg::out_t              out_q;

  logic [pdcm_pkg::TotW-1:0]   start_ext;
  logic [pdcm_pkg::TotW-1:0]   diff;
  logic [pdcm_pkg::TicksW-1:0] span;
  logic                        period_zero;
  logic                        duty_sat;
  logic [pdcm_pkg::NumW-1:0]   divisor;
  logic [pdcm_pkg::NumW:0]     trial;
  logic [pdcm_pkg::DutyW-1:0]  duty;

  // span = total - start, clamped at zero below and at 48 bits above
  assign start_ext = pdcm_pkg::TotW'(start_q);
  assign diff      = total_q - start_ext;
  always_comb begin
    if (total_q < start_ext) begin
      span = '0;
    end else if (diff[pdcm_pkg::TotW-1:pdcm_pkg::TicksW] != '0) begin
      span = '1;
    end else begin
      span = diff[pdcm_pkg::TicksW-1:0];
    end
  end

  assign period_zero = (period_q == '0);
  // quotient of 128 or more can only clamp to 100
  assign duty_sat = (num_q >= (pdcm_pkg::NumW'(period_q) << pdcm_pkg::DutyW));
  assign divisor  = pdcm_pkg::NumW'(period_q) << cnt_q;
  assign trial    = {1'b0, rem_q} - {1'b0, divisor};
  assign duty     = (quot_q > pdcm_pkg::DutyMax) ? pdcm_pkg::DutyMax : quot_q;

  assign status_o.div_skip = period_zero || duty_sat;
  assign status_o.div_last = (cnt_q == '0);
  assign out_data_o        = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q   <= '0;
      start_q <= '0;
      held_q  <= '0;
    end else begin
      if (cmd_i.ovf_inc && (ovf_q != '1)) begin
        ovf_q <= ovf_q + pdcm_pkg::OvfW'(1);
      end
      if (cmd_i.restart) begin
        ovf_q   <= '0;
        start_q <= cap_q;
      end
      if (cmd_i.held_load) begin
        held_q <= span;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_load) begin
      cap_q <= in_data_i.capture_value;
    end
    if (cmd_i.total_calc) begin
      total_q <= (pdcm_pkg::TotW'(ovf_q) << pdcm_pkg::SpanShift) + pdcm_pkg::TotW'(cap_q);
    end
    if (cmd_i.period_load) begin
      period_q <= span;
    end
    if (cmd_i.mul) begin
      num_q <= pdcm_pkg::NumW'(held_q) * pdcm_pkg::DutyScale;
    end
    if (cmd_i.div_init) begin
      zp_q  <= period_zero;
      rem_q <= num_q;
      cnt_q <= pdcm_pkg::CntW'(pdcm_pkg::DutyW - 1);
      if (!period_zero && duty_sat) begin
        quot_q <= pdcm_pkg::DutyMax;
      end else begin
        quot_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      if (!trial[pdcm_pkg::NumW]) begin
        rem_q         <= trial[pdcm_pkg::NumW-1:0];
        quot_q[cnt_q] <= 1'b1;
      end
      cnt_q <= cnt_q - pdcm_pkg::CntW'(1);
    end
    if (cmd_i.out_load) begin
      out_q.high_ticks   <= held_q;
      out_q.period_ticks <= period_q;
      out_q.duty_percent <= duty;
      out_q.zero_period  <= zp_q;
    end
  end

endmodule

// ===== hw/rtl/pdcm_ctrl.sv =====
// Controller of the PWM duty capture meter: edge phase, sequencing of the
// span and divide steps, and output valid. Uses pdcm_pkg.
module pdcm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pdcm_pkg::status_t status_i,
  output pdcm_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StTotal = 3'd1;
  localparam logic [2:0] StSpan  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StChk   = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StWait  = 3'd6;

  localparam logic [1:0] PhFirst  = 2'd0;
  localparam logic [1:0] PhHigh   = 2'd1;
  localparam logic [1:0] PhPeriod = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_opcode_i == pdcm_pkg::OpOverflow) begin
            cmd_o.ovf_inc = 1'b1;
          end else begin
            cmd_o.cap_load = 1'b1;
            state_d        = StTotal;
          end
        end
      end
      StTotal: begin
        cmd_o.total_calc = 1'b1;
        state_d          = StSpan;
      end
      StSpan: begin
        phase_d = PhHigh;
        unique case (phase_q)
          PhHigh: begin
            cmd_o.held_load = 1'b1;
            phase_d         = PhPeriod;
            state_d         = StIdle;
          end
          PhPeriod: begin
            cmd_o.period_load = 1'b1;
            cmd_o.restart     = 1'b1;
            state_d           = StMul;
          end
          default: begin
            // first rising edge, or the unused phase
            cmd_o.restart = 1'b1;
            state_d       = StIdle;
          end
        endcase
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StChk;
      end
      StChk: begin
        cmd_o.div_init = 1'b1;
        state_d        = status_i.div_skip ? StWait : StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StWait;
        end
      end
      StWait: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhFirst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_wait_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWait && out_free) |=> (out_valid_q && state_q == StIdle))
    else $error("result not posted after wait");

  a_edge_starts_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_opcode_i != pdcm_pkg::OpOverflow)
      |=> (state_q == StTotal))
    else $error("edge beat did not start span computation");

  a_div_after_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv || state_q == StChk) |-> (phase_q == PhHigh))
    else $error("divide running without restarted phase");

endmodule

// ===== hw/rtl/pwm_duty_capture_meter_top.sv =====
// PWM duty capture meter, top level.
// Joins pdcm_ctrl and pdcm_dpath; uses pdcm_pkg for payload types.

// Feed timer overflow beats (opcode 0) and edge capture beats (opcode 1) in
// arrival order; edges alternate rising, falling, rising from reset. An overflow
// beat is taken without a stall. A first rising or falling edge holds the input
// stalled for the total sum, then the span clamp. The rising edge that closes a
// period also holds it through the multiply and the 7-step restoring divider
// that forms the duty quotient (skipped when the period is zero or the duty
// clamps to 100), and while the previous result waits in the output register.
// One result beat appears per closing edge; all counts are in timer ticks.
module pwm_duty_capture_meter_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pdcm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pdcm_pkg::out_t out_data_o
);

  pdcm_pkg::cmd_t    cmd;
  pdcm_pkg::status_t status;

  pdcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pdcm_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for pwm_duty_capture_meter_top.
// Holds a scoreboard class that predicts each duty measurement, plus drivers for
// both valid/stall channels. Depends on pdcm_pkg and the top-level RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_OVERFLOW = pdcm_pkg::OpOverflow;
  localparam logic OP_EDGE     = pdcm_pkg::OpEdge;

  localparam int MAX_GAP      = 14;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 500;
  localparam int FREEZE_CYCLES = 500;

  localparam logic [pdcm_pkg::TicksW-1:0] TICKS_MAX = '1;

  typedef enum logic [1:0] {
    AWAIT_RISE,
    AWAIT_FALL,
    AWAIT_CLOSE,
    PHASE_SPARE
  } edge_phase_e;

  class pwm_meter_scoreboard;
    edge_phase_e                 phase;
    logic [pdcm_pkg::CapW-1:0]   start_stamp;
    logic [pdcm_pkg::OvfW-1:0]   ovf_count;
    logic [pdcm_pkg::TicksW-1:0] held_high;
    pdcm_pkg::out_t              expected_meas[$];
    int                          errors;
    int                          checked;
    int                          zero_periods;
    int                          duty_clamps;

    function new();
      phase        = AWAIT_RISE;
      start_stamp  = '0;
      ovf_count    = '0;
      held_high    = '0;
      errors       = 0;
      checked      = 0;
      zero_periods = 0;
      duty_clamps  = 0;
    endfunction

    // Ticks from the opening rising edge, clamped at zero and at the 48-bit max.
    function logic [pdcm_pkg::TicksW-1:0] ticks_since_start(
        logic [pdcm_pkg::CapW-1:0] cap);
      logic [63:0] total;
      total = 64'(ovf_count) * 64'(pdcm_pkg::CounterSpan) + 64'(cap);
      if (total < 64'(start_stamp)) return '0;
      total = total - 64'(start_stamp);
      if (total > 64'(TICKS_MAX)) return TICKS_MAX;
      return total[pdcm_pkg::TicksW-1:0];
    endfunction

    function void note_beat(pdcm_pkg::in_t beat);
      pdcm_pkg::out_t meas;
      logic [63:0]    duty;
      if (beat.opcode == OP_OVERFLOW) begin
        if (ovf_count != '1) ovf_count++;
        return;
      end
      if (phase == AWAIT_FALL) begin
        held_high = ticks_since_start(beat.capture_value);
        phase     = AWAIT_CLOSE;
        return;
      end
      if (phase == AWAIT_CLOSE) begin
        meas.high_ticks   = held_high;
        meas.period_ticks = ticks_since_start(beat.capture_value);
        meas.zero_period  = (meas.period_ticks == '0);
        duty = '0;
        if (meas.zero_period) begin
          zero_periods++;
        end else begin
          duty = 64'(held_high) * 64'(100) / 64'(meas.period_ticks);
          if (duty > 64'(100)) begin
            duty = 64'(100);
            duty_clamps++;
          end
        end
        meas.duty_percent = duty[pdcm_pkg::DutyW-1:0];
        expected_meas.push_back(meas);
      end
      // first rising edge, spare phase, or the closing edge: a new period opens
      start_stamp = beat.capture_value;
      ovf_count   = '0;
      phase       = AWAIT_FALL;
    endfunction

    function void check_result(pdcm_pkg::out_t got);
      pdcm_pkg::out_t exp;
      checked++;
      if (expected_meas.size() == 0) begin
        $error("result beat with no measurement pending");
        errors++;
        return;
      end
      exp = expected_meas.pop_front();
      if (got.high_ticks !== exp.high_ticks) begin
        $error("high_ticks: expected %0d, got %0d", exp.high_ticks, got.high_ticks);
        errors++;
      end
      if (got.period_ticks !== exp.period_ticks) begin
        $error("period_ticks: expected %0d, got %0d", exp.period_ticks, got.period_ticks);
        errors++;
      end
      if (got.duty_percent !== exp.duty_percent) begin
        $error("duty_percent: expected %0d, got %0d", exp.duty_percent, got.duty_percent);
        errors++;
      end
      if (got.zero_period !== exp.zero_period) begin
        $error("zero_period: expected %0d, got %0d", exp.zero_period, got.zero_period);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  pdcm_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  pdcm_pkg::out_t out_data_o;

  pwm_meter_scoreboard sb;

  int              cycles;
  int              beats;
  int              edges;
  bit              tx_idle;
  bit              rx_idle;
  int              rx_hold;
  int              rx_freeze;
  longint unsigned timer_now;
  longint unsigned next_wrap;

  pwm_duty_capture_meter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("run timed out after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result monitor; a new receiver hold is drawn after every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
      rx_hold = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_freeze != 0) begin
        out_stall_i <= 1'b1;
        rx_freeze--;
      end else if (rx_hold != 0) begin
        out_stall_i <= 1'b1;
        rx_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_beat(logic op, logic [pdcm_pkg::CapW-1:0] cap);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{opcode: op, capture_value: cap};
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat('{opcode: op, capture_value: cap});
    beats++;
    if (op == OP_EDGE) edges++;
  endtask

  // Timer overflows due at or before t go out first, then the edge with t's count.
  task automatic send_edge_at(longint unsigned t);
    while (t >= next_wrap) begin
      send_beat(OP_OVERFLOW, pdcm_pkg::CapW'($urandom));
      next_wrap += pdcm_pkg::CounterSpan;
    end
    send_beat(OP_EDGE, t[pdcm_pkg::CapW-1:0]);
  endtask

  task automatic run_periods(int n);
    longint unsigned period;
    longint unsigned high;
    int              sel;
    timer_now += $urandom_range(0, 100000);
    // one edge brings the meter back to awaiting a falling edge
    if (sb.phase != AWAIT_FALL) send_edge_at(timer_now);
    repeat (n) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) period = 0;
      else if (sel < 9) period = $urandom_range(1, 400);
      else if (sel < 17) period = $urandom_range(401, 70000);
      else period = $urandom_range(70001, 300000);
      high = longint'($urandom) % (period + 1);
      send_edge_at(timer_now + high);
      timer_now += period;
      send_edge_at(timer_now);
    end
  endtask

  task automatic send_noise(int n);
    logic [pdcm_pkg::CapW-1:0] cap;
    repeat (n) begin
      cap = pdcm_pkg::CapW'($urandom);
      if ($urandom_range(0, 3) == 0) cap = $urandom_range(0, 1) ? '1 : '0;
      send_beat(1'($urandom_range(0, 1)), cap);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_meas.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int  stop_at;
    bit  pressed;
    sb         = new();
    cycles     = 0;
    beats      = 0;
    edges      = 0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    rx_hold    = 0;
    rx_freeze  = 0;
    timer_now  = 0;
    next_wrap  = pdcm_pkg::CounterSpan;
    pressed    = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full-scale captures, zero and negative spans, duty above 100
    send_beat(OP_OVERFLOW, 16'hFFFF);
    send_beat(OP_EDGE, 16'h0000);
    send_beat(OP_EDGE, 16'hFFFF);
    send_beat(OP_OVERFLOW, 16'h0000);
    send_beat(OP_EDGE, 16'h0000);
    send_beat(OP_EDGE, 16'h0000);
    send_beat(OP_EDGE, 16'h0000);
    send_beat(OP_EDGE, 16'd500);
    send_beat(OP_EDGE, 16'd300);
    send_beat(OP_EDGE, 16'd100);
    send_beat(OP_EDGE, 16'd200);
    send_beat(OP_OVERFLOW, 16'h5A5A);
    send_beat(OP_OVERFLOW, 16'hA5A5);
    send_beat(OP_EDGE, 16'h8000);
    send_beat(OP_OVERFLOW, 16'h1234);
    send_beat(OP_EDGE, 16'h0001);
    send_beat(OP_EDGE, 16'hAAAA);
    send_beat(OP_OVERFLOW, 16'h0F0F);
    send_beat(OP_EDGE, 16'h5555);
    send_beat(OP_EDGE, 16'h5554);
    send_beat(OP_EDGE, 16'hFFFF);
    send_beat(OP_EDGE, 16'h5555);
    wait_drained();

    stop_at = beats + RANDOM_BEATS;
    while (beats < stop_at) begin
      if ($urandom_range(0, 3) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 3) == 0) rx_idle = !rx_idle;
      if (!pressed && beats > stop_at - RANDOM_BEATS / 2) begin
        // receiver freezes while the sender keeps pushing full periods
        pressed   = 1'b1;
        rx_freeze = FREEZE_CYCLES;
        tx_idle   = 1'b0;
        run_periods(8);
        wait_drained();
      end else if ($urandom_range(0, 4) != 0) begin
        run_periods($urandom_range(1, 6));
      end else begin
        send_noise($urandom_range(1, 5));
      end
    end
    wait_drained();

    $display("Sent %0d beats (%0d edges, rest overflows); checked %0d measurements.",
             beats, edges, sb.checked);
    $display("Zero-period results: %0d, duty clamped to 100: %0d.",
             sb.zero_periods, sb.duty_clamps);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
